[sv/abridged_length_deframer_top_defines.svh]
// Assertion macros shared by the deframer modules.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef ABRIDGED_LENGTH_DEFRAMER_TOP_DEFINES_SVH
`define ABRIDGED_LENGTH_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define ALD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define ALD_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ALD_ASSERT(lbl, prop, msg)
`define ALD_ASSERT_NR(lbl, prop, msg)
`endif

`endif

[sv/ald_pkg.sv]
package ald_pkg;

  // Header byte value at and above which a 3-byte word count follows.
  localparam logic [7:0] EXT_MARK = 8'h7f;

  // Kind of a result, carried on tuser.
  typedef enum logic [1:0] {
    ST_PAYLOAD = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ERROR   = 2'd2
  } status_e;

  // Results caused by one received byte. Either a single result, or (quad)
  // four payload bytes taken from data, lowest byte first, the last one
  // closing the frame.
  typedef struct packed {
    logic        valid;
    logic        quad;
    logic [31:0] data;
    logic        last;
    status_e     status;
    logic [31:0] code;
  } grp_t;

endpackage

[sv/abridged_length_deframer_top.sv]
// Path: a received byte that completes a result waits in the input register until it is loaded
//   into the output register, which shows the result on the master side.
// Throughput: one byte per cycle while no byte with a result waits; a four-byte frame releases
//   its results one per cycle from the output register while the master side is ready.
// Reset: rst_ni clears the frame state and both valid flags asynchronously; the block then
//   waits for a header byte and leaves the halted state only through reset.
module abridged_length_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side: received bytes.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // Master side: one result per transaction.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] data_byte, [39:8] error_code
  output logic        m_axis_tlast_o,   // last_of_frame
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);
  import ald_pkg::*;

  // Input register. It holds one received byte so that the slave side keeps
  // taking transactions while the output register waits on the master side, until a byte with a result waits in it.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  grp_t       grp;
  logic       can_load;
  logic       consume;
  logic       load;

  logic [7:0]  data_byte;
  logic [31:0] error_code;

  // A byte that causes no result is consumed at once; one that does waits
  // until the output register has room for its whole group of results.
  assign consume = in_valid_q && (!grp.valid || can_load);
  assign load    = consume && grp.valid;

  assign s_axis_tready_o = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // Frame state machine: header, extended count, payload and the hold-back
  // check of four-byte frames, all decided combinationally as each byte is taken.
  ald_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (in_byte_q),
    .take_i (consume),
    .grp_o  (grp)
  );

  // Output register. It holds the results of one byte and hands them out one
  // transaction at a time.
  ald_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .grp_i       (grp),
    .can_load_o  (can_load),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .data_byte_o (data_byte),
    .last_o      (m_axis_tlast_o),
    .status_o    (m_axis_tuser_o),
    .code_o      (error_code)
  );

  assign m_axis_tdata_o = {error_code, data_byte};

endmodule

[sv/ald_parser.sv]
`include "abridged_length_deframer_top_defines.svh"

module ald_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    byte_i,
  input  logic          take_i,
  output ald_pkg::grp_t grp_o
);
  import ald_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_EXT,
    PH_PAYLOAD,
    PH_HALTED
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  ext_cnt_q, ext_cnt_d;
  logic [15:0] wc_acc_q, wc_acc_d;
  logic [25:0] rem_q, rem_d;
  logic        short_q, short_d;
  logic [7:0]  held_q [3];
  logic [7:0]  held_d [3];

  logic        start;
  logic [23:0] words;
  logic [1:0]  pos;

  always_comb begin
    phase_d   = phase_q;
    ext_cnt_d = ext_cnt_q;
    wc_acc_d  = wc_acc_q;
    rem_d     = rem_q;
    short_d   = short_q;
    held_d    = held_q;
    grp_o     = '0;
    start     = 1'b0;
    words     = '0;
    pos       = 2'd0 - rem_q[1:0];

    unique case (phase_q)
      PH_HEADER: begin
        if (byte_i < EXT_MARK) begin
          start = 1'b1;
          words = 24'(byte_i);
        end else begin
          phase_d   = PH_EXT;
          ext_cnt_d = 2'd0;
          wc_acc_d  = '0;
        end
      end
      PH_EXT: begin
        if (ext_cnt_q == 2'd2) begin
          start     = 1'b1;
          words     = {byte_i, wc_acc_q};
          ext_cnt_d = 2'd0;
        end else begin
          wc_acc_d  = ext_cnt_q[0] ? {byte_i, wc_acc_q[7:0]} : {8'h00, byte_i};
          ext_cnt_d = ext_cnt_q + 2'd1;
        end
      end
      PH_PAYLOAD: begin
        if (short_q) begin
          if (rem_q != 26'd1) begin
            for (int i = 0; i < 3; i++) begin
              if (pos == 2'(i)) begin
                held_d[i] = byte_i;
              end
            end
            rem_d = rem_q - 26'd1;
          end else begin
            short_d      = 1'b0;
            rem_d        = '0;
            grp_o.valid  = 1'b1;
            grp_o.last   = 1'b1;
            if (byte_i[7]) begin
              // A negative word is a transport error code; stop for good.
              phase_d      = PH_HALTED;
              grp_o.status = ST_ERROR;
              grp_o.code   = {byte_i, held_q[2], held_q[1], held_q[0]};
            end else begin
              phase_d      = PH_HEADER;
              grp_o.quad   = 1'b1;
              grp_o.status = ST_PAYLOAD;
              grp_o.data   = {byte_i, held_q[2], held_q[1], held_q[0]};
            end
          end
        end else begin
          rem_d        = rem_q - 26'd1;
          grp_o.valid  = 1'b1;
          grp_o.status = ST_PAYLOAD;
          grp_o.data   = 32'(byte_i);
          grp_o.last   = (rem_q == 26'd1);
          if (rem_q == 26'd1) begin
            phase_d = PH_HEADER;
          end
        end
      end
      PH_HALTED: begin
        phase_d = PH_HALTED;
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase

    if (start) begin
      if (words == 24'd0) begin
        phase_d      = PH_HEADER;
        grp_o.valid  = 1'b1;
        grp_o.last   = 1'b1;
        grp_o.status = ST_EMPTY;
      end else begin
        rem_d   = {words, 2'b00};
        short_d = (words == 24'd1);
        phase_d = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      ext_cnt_q <= '0;
      wc_acc_q  <= '0;
      rem_q     <= '0;
      short_q   <= 1'b0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      ext_cnt_q <= ext_cnt_d;
      wc_acc_q  <= wc_acc_d;
      rem_q     <= rem_d;
      short_q   <= short_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      held_q <= held_d;
    end
  end

  `ALD_ASSERT(a_halt_sticky, (phase_q == PH_HALTED) |=> (phase_q == PH_HALTED), "halt left without reset")
  `ALD_ASSERT(a_err_halts, (take_i && grp_o.valid && grp_o.status == ST_ERROR) |=> (phase_q == PH_HALTED), "error did not halt")
  `ALD_ASSERT(a_short_rem, !short_q || (rem_q != 26'd0 && rem_q <= 26'd4), "short frame count out of range")

endmodule

[sv/ald_outq.sv]
`include "abridged_length_deframer_top_defines.svh"

module ald_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  ald_pkg::grp_t grp_i,
  output logic          can_load_o,
  output logic          m_tvalid_o,
  input  logic          m_tready_i,
  output logic [7:0]    data_byte_o,
  output logic          last_o,
  output logic [1:0]    status_o,
  output logic [31:0]   code_o
);
  import ald_pkg::*;

  grp_t       grp_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic       final_res;

  // The group's final result is the only one for a single, the fourth for a quad.
  assign final_res   = !grp_q.quad || (idx_q == 2'd3);
  assign can_load_o  = !valid_q || (m_tready_i && final_res);

  assign m_tvalid_o  = valid_q;
  assign data_byte_o = grp_q.quad ? 8'(grp_q.data >> {idx_q, 3'b000}) : grp_q.data[7:0];
  assign last_o      = grp_q.quad ? (idx_q == 2'd3) : grp_q.last;
  assign status_o    = grp_q.status;
  assign code_o      = grp_q.code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && m_tready_i) begin
      if (final_res) begin
        valid_q <= 1'b0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

  `ALD_ASSERT(a_idx_quad, (idx_q != 2'd0) |-> (valid_q && grp_q.quad), "index moved outside a quad")
  `ALD_ASSERT(a_load_room, load_i |-> can_load_o, "group loaded over a pending one")
  `ALD_ASSERT(a_step, (valid_q && m_tready_i && !final_res) |=> (valid_q && idx_q == 2'($past(idx_q) + 2'd1)), "quad did not advance")

endmodule

[tb/abridged_length_deframer_top_tb.sv]
module abridged_length_deframer_top_tb;
  import ald_pkg::*;

  // One result as it leaves the master side, split into its fields.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last;
    status_e     status;
    logic [31:0] code;
  } frame_result_t;

  // Tracks the deframing state on its own and holds the results that the
  // received bytes should produce, oldest first.
  class deframe_scoreboard;
    typedef enum logic [1:0] {
      AWAIT_HDR = 2'd0,
      EXT_COUNT = 2'd1,
      IN_FRAME  = 2'd2,
      HALTED    = 2'd3
    } deframe_phase_e;

    deframe_phase_e phase_q;
    logic [1:0]     ext_seen;
    logic [23:0]    word_acc;
    logic [25:0]    left_bytes;
    logic           four_byte;
    logic [7:0]     held [3];

    frame_result_t  expected_q [$];
    int unsigned    bytes_in;
    int unsigned    checked;
    int unsigned    empties;
    int unsigned    quads;
    int unsigned    halts;
    int unsigned    errors;

    function new();
      phase_q    = AWAIT_HDR;
      ext_seen   = '0;
      word_acc   = '0;
      left_bytes = '0;
      four_byte  = 1'b0;
      foreach (held[i]) held[i] = '0;
      bytes_in   = 0;
      checked    = 0;
      empties    = 0;
      quads      = 0;
      halts      = 0;
      errors     = 0;
    endfunction

    function void push(logic [7:0] d, logic l, status_e s, logic [31:0] c);
      frame_result_t r;
      r.data_byte = d;
      r.last      = l;
      r.status    = s;
      r.code      = c;
      expected_q.push_back(r);
    endfunction

    // A word count of zero closes the frame at once with an empty result.
    function void open_frame(logic [23:0] words);
      if (words == 24'd0) begin
        phase_q = AWAIT_HDR;
        empties++;
        push(8'h00, 1'b1, ST_EMPTY, 32'h0);
      end else begin
        left_bytes = {words, 2'b00};
        four_byte  = (words == 24'd1);
        phase_q    = IN_FRAME;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [1:0] pos;
      if (phase_q != HALTED) bytes_in++;
      case (phase_q)
        AWAIT_HDR: begin
          if (b < EXT_MARK) begin
            open_frame({16'h0, b});
          end else begin
            phase_q  = EXT_COUNT;
            ext_seen = '0;
            word_acc = '0;
          end
        end
        EXT_COUNT: begin
          word_acc = word_acc | (24'(b) << (8 * ext_seen));
          ext_seen = ext_seen + 2'd1;
          if (ext_seen == 2'd3) begin
            ext_seen = '0;
            open_frame(word_acc);
          end
        end
        IN_FRAME: begin
          if (four_byte) begin
            pos        = 2'(26'd4 - left_bytes);
            left_bytes = left_bytes - 26'd1;
            if (pos != 2'd3) begin
              held[pos] = b;
            end else begin
              four_byte  = 1'b0;
              left_bytes = '0;
              if (b[7]) begin
                // A negative word is a transport error; nothing follows it.
                phase_q = HALTED;
                halts++;
                push(8'h00, 1'b1, ST_ERROR, {b, held[2], held[1], held[0]});
              end else begin
                phase_q = AWAIT_HDR;
                quads++;
                push(held[0], 1'b0, ST_PAYLOAD, 32'h0);
                push(held[1], 1'b0, ST_PAYLOAD, 32'h0);
                push(held[2], 1'b0, ST_PAYLOAD, 32'h0);
                push(b, 1'b1, ST_PAYLOAD, 32'h0);
              end
            end
          end else begin
            left_bytes = left_bytes - 26'd1;
            if (left_bytes == 26'd0) begin
              phase_q = AWAIT_HDR;
              push(b, 1'b1, ST_PAYLOAD, 32'h0);
            end else begin
              push(b, 1'b0, ST_PAYLOAD, 32'h0);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [7:0] d, logic l, logic [1:0] s, logic [31:0] c);
      frame_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: data_byte %0h last %0b status %0d code %0h", d, l, s, c);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (d !== exp_r.data_byte) begin
        $error("data_byte: expected %0h, got %0h", exp_r.data_byte, d);
        errors++;
      end
      if (l !== exp_r.last) begin
        $error("last_of_frame: expected %0b, got %0b", exp_r.last, l);
        errors++;
      end
      if (s !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, s);
        errors++;
      end
      if (c !== exp_r.code) begin
        $error("error_code: expected %0h, got %0h", exp_r.code, c);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void report_leftover();
      if (expected_q.size() != 0) begin
        $error("%0d expected results never arrived", expected_q.size());
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] rx_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;   // [7:0] data_byte, [39:8] error_code
  logic        m_axis_tlast_o;   // last_of_frame
  logic [1:0]  m_axis_tuser_o;   // [1:0] status

  deframe_scoreboard sb;

  // Idling switches for both sides, changed per frame so that stretches of
  // back-to-back traffic alternate with random gaps.
  bit tx_idle_on;
  bit rx_idle_on;
  // Long receiver hold-off, requested by the stimulus and timed by its own process.
  bit hold_req;
  bit hold_rx;

  abridged_length_deframer_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Offers one byte, after a random gap if sender idling is on and the hold-off
  // is not running, and returns at the edge where the transaction completes. Valid
  // stays high so that a byte with no gap follows without a bubble.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (tx_idle_on && !hold_rx) ? $urandom_range(0, 11) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_byte(b);
  endtask

  // Sends a whole frame: the short or the extended header, then the payload.
  // A one-word frame keeps the sign bit of its last byte clear unless an
  // error is wanted, since an error halts the block for the rest of the run.
  task automatic send_frame(input logic [23:0] words, input bit ext_form, input bit make_error);
    int unsigned n;
    logic [7:0] b;
    if (ext_form) begin
      send_byte(8'($urandom_range(8'h7f, 8'hff)));
      send_byte(words[7:0]);
      send_byte(words[15:8]);
      send_byte(words[23:16]);
    end else begin
      send_byte(words[7:0]);
    end
    n = words * 4;
    for (int unsigned i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (words == 24'd1 && i == 3) b[7] = make_error;
      send_byte(b);
    end
  endtask

  // Holds the sender until every predicted result has been taken.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: a random stall before each result while receiver idling is on, plus the long hold-off.
  initial begin
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = rx_idle_on ? $urandom_range(0, 11) : 0;
      for (int unsigned i = 0; i < stall; i++) begin
        m_axis_tready_i = 1'b0;
        @(negedge clk_i);
      end
      while (hold_rx) begin
        m_axis_tready_i = 1'b0;
        @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_result(m_axis_tdata_o[7:0], m_axis_tlast_o, m_axis_tuser_o,
                      m_axis_tdata_o[39:8]);
    end
  end

  // Counts out the long receiver hold-off once it is requested.
  initial begin
    hold_rx = 1'b0;
    wait (hold_req);
    @(negedge clk_i);
    hold_rx = 1'b1;
    repeat (200) @(negedge clk_i);
    hold_rx = 1'b0;
  end

  // Safety net against a hung handshake.
  initial begin
    #2000000;
    $display("abridged_length_deframer_top test failed");
    $finish;
  end

  initial begin
    // Directed bytes: empty frames in both header forms, one-word frames in
    // both forms with the smallest and the largest non-negative word, and a
    // two-word frame with the byte extremes.
    logic [7:0] directed_seq [] = '{
      8'h00,
      8'h7f, 8'h00, 8'h00, 8'h00,
      8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
      8'hff, 8'h01, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'h7f,
      8'h02, 8'h00, 8'hff, 8'h80, 8'h7f, 8'h55, 8'haa, 8'h01, 8'hfe
    };
    int unsigned kind;
    int unsigned waited;

    sb              = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    tx_idle_on      = 1'b0;
    rx_idle_on      = 1'b0;
    hold_req        = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_seq[i]) send_byte(directed_seq[i]);

    // The sender pauses here until the directed results are all out.
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    wait_drained();

    // Back-to-back bytes against a receiver that holds off long enough for
    // the block to fill up and push back on its input.
    hold_req = 1'b1;
    send_frame(24'd20, 1'b0, 1'b0);
    send_frame(24'd1, 1'b0, 1'b0);
    send_frame(24'd1, 1'b1, 1'b0);

    // Random frames; the one-word kind is weighted up since it is the case
    // that exercises the holding and the sign check.
    while (sb.bytes_in < 370) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        send_frame(24'd0, kind[0], 1'b0);
      end else if (kind < 8) begin
        send_frame(24'd1, $urandom_range(0, 3) == 0, 1'b0);
      end else if (kind < 16) begin
        send_frame(24'($urandom_range(2, 6)), 1'b0, 1'b0);
      end else begin
        send_frame(24'($urandom_range(2, 8)), 1'b1, 1'b0);
      end
    end

    // Last of all a transport error with the most negative code. Every byte
    // after it must be swallowed without a result.
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    wait_drained();
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h80);
    repeat (6) send_byte(8'($urandom));
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    // Allow a margin for stray results.
    repeat (20) @(posedge clk_i);
    sb.report_leftover();

    $display("Covered %0d received bytes and %0d checked results, with %0d empty frames,",
             sb.bytes_in, sb.checked, sb.empties);
    $display("%0d released four-byte frames and %0d transport-error halt.",
             sb.quads, sb.halts);
    if (sb.errors == 0) begin
      $display("abridged_length_deframer_top test passed");
    end else begin
      $display("abridged_length_deframer_top test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/ald_pkg.sv
sv/ald_parser.sv
sv/ald_outq.sv
sv/abridged_length_deframer_top.sv
tb/abridged_length_deframer_top_tb.sv
